// File: design/hclb_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code length builder package
// Action codes, result kinds, field widths and the queued item type shared by
// the front and back parts of the block.
// ----------------------------------------------------------------------------
package hclb_pkg;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic KIND_TOTALS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    localparam int UNC_W   = 27;
    localparam int COMP_W  = 27;
    localparam int FREQ_W  = 24;
    localparam int LEN_W   = 7;
    localparam int TOTAL_W = 24;

    localparam logic [LEN_W-1:0]   LEN_MAX   = 7'd127;
    localparam logic [FREQ_W-1:0]  FREQ_MAX  = 24'hFFFFFF;
    localparam logic [COMP_W-1:0]  COMP_MAX  = 27'h7FFFFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0] op;
        logic       last;
        logic       in_range;
        logic [7:0] byte_value;
        logic [6:0] symbol;
    } item_t;

endpackage

// File: design/hclb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module hclb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

// File: design/hclb_front.sv
// ----------------------------------------------------------------------------
// Huffman code length builder front part
// Accepts input transfers, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module hclb_front #(
    parameter int SYMBOLS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_action,
    input  logic [7:0]          s_byte_value,
    input  logic                s_last,
    input  logic [6:0]          s_symbol,
    output logic                q_valid,
    output hclb_pkg::item_t     q_item,
    input  logic                q_pop
);

    hclb_pkg::item_t in_item;
    hclb_pkg::item_t fifo_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push;

    always_comb begin
        in_item.op         = s_action;
        in_item.last       = (s_action == hclb_pkg::ACT_BYTE) && s_last;
        in_item.byte_value = s_byte_value;
        in_item.symbol     = s_symbol;
        unique case (s_action)
            hclb_pkg::ACT_BYTE: in_item.in_range = 32'(s_byte_value) < SYMBOLS;
            hclb_pkg::ACT_READ: in_item.in_range = 32'(s_symbol) < SYMBOLS;
            default:            in_item.in_range = 1'b0;
        endcase
    end

    assign s_ready = cnt_reg != 2'd2;
    assign push    = s_valid && s_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: design/hclb_back.sv
// ----------------------------------------------------------------------------
// Huffman code length builder back part
// Counts symbols, answers readouts, handles clears and builds the code lengths after the last
// byte by repeated two-minimum scans over the node weights.
// ----------------------------------------------------------------------------
module hclb_back #(
    parameter int SYMBOLS    = 128,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  hclb_pkg::item_t                      q_item,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [hclb_pkg::UNC_W-1:0]           m_uncompressed_bits,
    output logic [hclb_pkg::COMP_W-1:0]          m_compressed_bits,
    output logic                                 m_present,
    output logic [hclb_pkg::FREQ_W-1:0]          m_symbol_freq,
    output logic [hclb_pkg::LEN_W-1:0]           m_code_length,
    output logic                                 m_overflow
);

    localparam int SYM_W  = $clog2(SYMBOLS);
    localparam int NODES  = 2 * SYMBOLS - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int WGT_W  = COUNT_BITS + SYM_W;
    localparam int PROD_W = COUNT_BITS + hclb_pkg::LEN_W;
    localparam int SUM_W  = ((PROD_W > hclb_pkg::COMP_W) ? PROD_W : hclb_pkg::COMP_W) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] ST_RUN     = 4'd0;
    localparam logic [3:0] ST_INIT_RD = 4'd1;
    localparam logic [3:0] ST_INIT_WR = 4'd2;
    localparam logic [3:0] ST_CHECK   = 4'd3;
    localparam logic [3:0] ST_SCAN    = 4'd4;
    localparam logic [3:0] ST_MERGE0  = 4'd5;
    localparam logic [3:0] ST_MERGE1  = 4'd6;
    localparam logic [3:0] ST_MERGE2  = 4'd7;
    localparam logic [3:0] ST_DEP_A   = 4'd8;
    localparam logic [3:0] ST_DEP_B   = 4'd9;
    localparam logic [3:0] ST_DEP_C   = 4'd10;
    localparam logic [3:0] ST_LEN_A   = 4'd11;
    localparam logic [3:0] ST_LEN_B   = 4'd12;
    localparam logic [3:0] ST_LEN_C   = 4'd13;
    localparam logic [3:0] ST_DONE    = 4'd14;

    logic [3:0]                    st_reg, st_next;
    logic                          stage_v_reg, stage_v_next;
    hclb_pkg::item_t               stage_item_reg, stage_item_next;
    logic [SYMBOLS-1:0]            cnt_valid_reg, cnt_valid_next;
    logic [SYMBOLS-1:0]            len_valid_reg, len_valid_next;
    logic [hclb_pkg::TOTAL_W-1:0]  byte_total_reg, byte_total_next;
    logic                          ovf_reg, ovf_next;
    logic                          fwd_v_reg, fwd_v_next;
    logic [SYM_W-1:0]              fwd_addr_reg, fwd_addr_next;
    logic [COUNT_BITS-1:0]         fwd_data_reg, fwd_data_next;

    logic                          mv_reg, mv_next;
    logic                          kind_reg, kind_next;
    logic [hclb_pkg::UNC_W-1:0]    unc_reg, unc_next;
    logic [hclb_pkg::COMP_W-1:0]   ocomp_reg, ocomp_next;
    logic                          pres_reg, pres_next;
    logic [hclb_pkg::FREQ_W-1:0]   freq_reg, freq_next;
    logic [hclb_pkg::LEN_W-1:0]    olen_reg, olen_next;
    logic                          oovf_reg, oovf_next;

    logic [SYM_W:0]                s_reg, s_next;
    logic [NODE_W-1:0]             used_reg, used_next;
    logic [SYM_W:0]                live_reg, live_next;
    logic [NODE_W-1:0]             scan_idx_reg, scan_idx_next;
    logic                          rd_v_reg, rd_v_next;
    logic [NODE_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                          best_ok_reg, best_ok_next;
    logic [NODE_W-1:0]             best_idx_reg, best_idx_next;
    logic [WGT_W-1:0]              best_w_reg, best_w_next;
    logic                          second_ok_reg, second_ok_next;
    logic [NODE_W-1:0]             second_idx_reg, second_idx_next;
    logic [WGT_W-1:0]              second_w_reg, second_w_next;
    logic [NODE_W-1:0]             j_reg, j_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [hclb_pkg::COMP_W-1:0]   comp_reg, comp_next;

    logic                          cnt_we, cnt_re;
    logic [SYM_W-1:0]              cnt_wa, cnt_ra;
    logic [COUNT_BITS-1:0]         cnt_wd, cnt_rd;
    logic                          len_we, len_re;
    logic [SYM_W-1:0]              len_wa, len_ra;
    logic [hclb_pkg::LEN_W-1:0]    len_wd, len_rd;
    logic                          wgt_we, wgt_re;
    logic [NODE_W-1:0]             wgt_wa, wgt_ra;
    logic [WGT_W:0]                wgt_wd, wgt_rd;
    logic                          par_we, par_re;
    logic [NODE_W-1:0]             par_wa, par_ra;
    logic [NODE_W-1:0]             par_wd, par_rd;
    logic                          dep_we, dep_re;
    logic [NODE_W-1:0]             dep_wa, dep_ra;
    logic [NODE_W-1:0]             dep_wd, dep_rd;

    logic [SYM_W-1:0]              stage_addr, head_addr, sidx;
    logic [COUNT_BITS-1:0]         stage_cnt, build_cnt, cnt_inc;
    logic [hclb_pkg::LEN_W-1:0]    dep_sat, len_val;
    logic [SUM_W-1:0]              sum;
    logic                          head_needs_out;

    hclb_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_cnt_ram (
        .aclk(aclk), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
        .rd_en(cnt_re), .rd_addr(cnt_ra), .rd_data(cnt_rd)
    );
    hclb_ram #(.WIDTH(hclb_pkg::LEN_W), .DEPTH(SYMBOLS)) u_len_ram (
        .aclk(aclk), .wr_en(len_we), .wr_addr(len_wa), .wr_data(len_wd),
        .rd_en(len_re), .rd_addr(len_ra), .rd_data(len_rd)
    );
    // The top bit of each node weight word marks a live node: nonzero and not yet merged.
    hclb_ram #(.WIDTH(WGT_W + 1), .DEPTH(NODES)) u_wgt_ram (
        .aclk(aclk), .wr_en(wgt_we), .wr_addr(wgt_wa), .wr_data(wgt_wd),
        .rd_en(wgt_re), .rd_addr(wgt_ra), .rd_data(wgt_rd)
    );
    hclb_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_par_ram (
        .aclk(aclk), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
        .rd_en(par_re), .rd_addr(par_ra), .rd_data(par_rd)
    );
    hclb_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_dep_ram (
        .aclk(aclk), .wr_en(dep_we), .wr_addr(dep_wa), .wr_data(dep_wd),
        .rd_en(dep_re), .rd_addr(dep_ra), .rd_data(dep_rd)
    );

    assign stage_addr = (stage_item_reg.op == hclb_pkg::ACT_BYTE) ?
                        SYM_W'(stage_item_reg.byte_value) : SYM_W'(stage_item_reg.symbol);
    assign head_addr  = (q_item.op == hclb_pkg::ACT_BYTE) ?
                        SYM_W'(q_item.byte_value) : SYM_W'(q_item.symbol);
    assign sidx       = s_reg[SYM_W-1:0];

    assign stage_cnt = (fwd_v_reg && fwd_addr_reg == stage_addr) ? fwd_data_reg :
                       (cnt_valid_reg[stage_addr] ? cnt_rd : '0);
    assign build_cnt = cnt_valid_reg[sidx] ? cnt_rd : '0;
    assign cnt_inc   = (stage_cnt != CNT_MAX) ? stage_cnt + 1'b1 : stage_cnt;

    assign dep_sat = (32'(dep_rd) > 32'(hclb_pkg::LEN_MAX)) ? hclb_pkg::LEN_MAX
                                                             : hclb_pkg::LEN_W'(dep_rd);
    assign len_val = (build_cnt != '0) ? dep_sat : '0;
    assign sum     = SUM_W'(comp_reg) + SUM_W'(prod_reg);

    assign head_needs_out = (q_item.op == hclb_pkg::ACT_READ) || q_item.last;

    always_comb begin
        st_next         = st_reg;
        stage_v_next    = 1'b0;
        stage_item_next = stage_item_reg;
        cnt_valid_next  = cnt_valid_reg;
        len_valid_next  = len_valid_reg;
        byte_total_next = byte_total_reg;
        ovf_next        = ovf_reg;
        fwd_v_next      = 1'b0;
        fwd_addr_next   = fwd_addr_reg;
        fwd_data_next   = fwd_data_reg;
        mv_next         = mv_reg && !m_ready;
        kind_next       = kind_reg;
        unc_next        = unc_reg;
        ocomp_next      = ocomp_reg;
        pres_next       = pres_reg;
        freq_next       = freq_reg;
        olen_next       = olen_reg;
        oovf_next       = oovf_reg;
        s_next          = s_reg;
        used_next       = used_reg;
        live_next       = live_reg;
        scan_idx_next   = scan_idx_reg;
        rd_v_next       = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_ok_next    = best_ok_reg;
        best_idx_next   = best_idx_reg;
        best_w_next     = best_w_reg;
        second_ok_next  = second_ok_reg;
        second_idx_next = second_idx_reg;
        second_w_next   = second_w_reg;
        j_next          = j_reg;
        prod_next       = prod_reg;
        comp_next       = comp_reg;
        q_pop  = 1'b0;
        cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_re = 1'b0; cnt_ra = '0;
        len_we = 1'b0; len_wa = '0; len_wd = '0; len_re = 1'b0; len_ra = '0;
        wgt_we = 1'b0; wgt_wa = '0; wgt_wd = '0; wgt_re = 1'b0; wgt_ra = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0; par_re = 1'b0; par_ra = '0;
        dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_re = 1'b0; dep_ra = '0;

        unique case (st_reg)
            ST_RUN: begin
                if (stage_v_reg) begin
                    unique case (stage_item_reg.op)
                        hclb_pkg::ACT_BYTE: begin
                            if (byte_total_reg != hclb_pkg::TOTAL_MAX) begin
                                byte_total_next = byte_total_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                            if (stage_item_reg.in_range) begin
                                if (stage_cnt == CNT_MAX) begin
                                    ovf_next = 1'b1;
                                end
                                cnt_we = 1'b1;
                                cnt_wa = stage_addr;
                                cnt_wd = cnt_inc;
                                cnt_valid_next[stage_addr] = 1'b1;
                                fwd_v_next    = 1'b1;
                                fwd_addr_next = stage_addr;
                                fwd_data_next = cnt_inc;
                            end
                            if (stage_item_reg.last) begin
                                st_next     = ST_INIT_RD;
                                s_next      = '0;
                                used_next   = NODE_W'(SYMBOLS);
                                live_next   = '0;
                                comp_next   = '0;
                            end
                        end
                        hclb_pkg::ACT_READ: begin
                            mv_next    = 1'b1;
                            kind_next  = hclb_pkg::KIND_ENTRY;
                            unc_next   = '0;
                            ocomp_next = '0;
                            pres_next  = stage_item_reg.in_range && stage_cnt != '0;
                            freq_next  = '0;
                            olen_next  = '0;
                            oovf_next  = ovf_reg;
                            if (stage_item_reg.in_range) begin
                                freq_next = (32'(stage_cnt) > 32'(hclb_pkg::FREQ_MAX)) ?
                                            hclb_pkg::FREQ_MAX : hclb_pkg::FREQ_W'(stage_cnt);
                                olen_next = len_valid_reg[stage_addr] ? len_rd : '0;
                            end
                        end
                        hclb_pkg::ACT_CLEAR: begin
                            cnt_valid_next  = '0;
                            len_valid_next  = '0;
                            byte_total_next = '0;
                            ovf_next        = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                if (q_valid && !(stage_v_reg && stage_item_reg.last) &&
                    (!head_needs_out || (!mv_reg && !(stage_v_reg &&
                     stage_item_reg.op == hclb_pkg::ACT_READ)))) begin
                    q_pop           = 1'b1;
                    stage_v_next    = 1'b1;
                    stage_item_next = q_item;
                    cnt_re          = 1'b1;
                    cnt_ra          = head_addr;
                    len_re          = 1'b1;
                    len_ra          = head_addr;
                end
            end
            ST_INIT_RD: begin
                cnt_re  = 1'b1;
                cnt_ra  = sidx;
                st_next = ST_INIT_WR;
            end
            ST_INIT_WR: begin
                wgt_we = 1'b1;
                wgt_wa = NODE_W'(sidx);
                wgt_wd = {build_cnt != '0, WGT_W'(build_cnt)};
                par_we = 1'b1;
                par_wa = NODE_W'(sidx);
                par_wd = NODE_W'(sidx);
                if (build_cnt != '0) begin
                    live_next = live_reg + 1'b1;
                end
                if (s_reg == (SYM_W+1)'(SYMBOLS - 1)) begin
                    st_next = ST_CHECK;
                end else begin
                    s_next  = s_reg + 1'b1;
                    st_next = ST_INIT_RD;
                end
            end
            ST_CHECK: begin
                if (live_reg >= (SYM_W+1)'(2)) begin
                    st_next        = ST_SCAN;
                    scan_idx_next  = '0;
                    best_ok_next   = 1'b0;
                    second_ok_next = 1'b0;
                end else begin
                    st_next = ST_DEP_A;
                    j_next  = used_reg - 1'b1;
                end
            end
            ST_SCAN: begin
                if (rd_v_reg && wgt_rd[WGT_W]) begin
                    if (!best_ok_reg || wgt_rd[WGT_W-1:0] < best_w_reg) begin
                        second_ok_next  = best_ok_reg;
                        second_idx_next = best_idx_reg;
                        second_w_next   = best_w_reg;
                        best_ok_next    = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_w_next     = wgt_rd[WGT_W-1:0];
                    end else if (!second_ok_reg || wgt_rd[WGT_W-1:0] < second_w_reg) begin
                        second_ok_next  = 1'b1;
                        second_idx_next = rd_idx_reg;
                        second_w_next   = wgt_rd[WGT_W-1:0];
                    end
                end
                if (scan_idx_reg != used_reg) begin
                    wgt_re        = 1'b1;
                    wgt_ra        = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + 1'b1;
                    rd_v_next     = 1'b1;
                    rd_idx_next   = scan_idx_reg;
                end else if (!rd_v_reg) begin
                    st_next = ST_MERGE0;
                end
            end
            ST_MERGE0: begin
                wgt_we  = 1'b1;
                wgt_wa  = used_reg;
                wgt_wd  = {1'b1, WGT_W'(best_w_reg + second_w_reg)};
                par_we  = 1'b1;
                par_wa  = used_reg;
                par_wd  = used_reg;
                st_next = ST_MERGE1;
            end
            ST_MERGE1: begin
                wgt_we  = 1'b1;
                wgt_wa  = best_idx_reg;
                wgt_wd  = {1'b0, best_w_reg};
                par_we  = 1'b1;
                par_wa  = best_idx_reg;
                par_wd  = used_reg;
                st_next = ST_MERGE2;
            end
            ST_MERGE2: begin
                wgt_we = 1'b1;
                wgt_wa = second_idx_reg;
                wgt_wd = {1'b0, second_w_reg};
                par_we = 1'b1;
                par_wa = second_idx_reg;
                par_wd = used_reg;
                used_next = used_reg + 1'b1;
                live_next = live_reg - 1'b1;
                st_next   = ST_CHECK;
            end
            ST_DEP_A: begin
                par_re  = 1'b1;
                par_ra  = j_reg;
                st_next = ST_DEP_B;
            end
            ST_DEP_B: begin
                if (par_rd == j_reg) begin
                    dep_we = 1'b1;
                    dep_wa = j_reg;
                    dep_wd = '0;
                    if (j_reg == '0) begin
                        st_next = ST_LEN_A;
                        s_next  = '0;
                    end else begin
                        j_next  = j_reg - 1'b1;
                        st_next = ST_DEP_A;
                    end
                end else begin
                    dep_re  = 1'b1;
                    dep_ra  = par_rd;
                    st_next = ST_DEP_C;
                end
            end
            ST_DEP_C: begin
                dep_we = 1'b1;
                dep_wa = j_reg;
                dep_wd = dep_rd + 1'b1;
                if (j_reg == '0) begin
                    st_next = ST_LEN_A;
                    s_next  = '0;
                end else begin
                    j_next  = j_reg - 1'b1;
                    st_next = ST_DEP_A;
                end
            end
            ST_LEN_A: begin
                cnt_re  = 1'b1;
                cnt_ra  = sidx;
                dep_re  = 1'b1;
                dep_ra  = NODE_W'(sidx);
                st_next = ST_LEN_B;
            end
            ST_LEN_B: begin
                len_we = 1'b1;
                len_wa = sidx;
                len_wd = len_val;
                len_valid_next[sidx] = 1'b1;
                prod_next = PROD_W'(build_cnt) * PROD_W'(len_val);
                st_next   = ST_LEN_C;
            end
            ST_LEN_C: begin
                comp_next = (sum > SUM_W'(hclb_pkg::COMP_MAX)) ? hclb_pkg::COMP_MAX
                                                               : hclb_pkg::COMP_W'(sum);
                if (s_reg == (SYM_W+1)'(SYMBOLS - 1)) begin
                    st_next = ST_DONE;
                end else begin
                    s_next  = s_reg + 1'b1;
                    st_next = ST_LEN_A;
                end
            end
            ST_DONE: begin
                mv_next    = 1'b1;
                kind_next  = hclb_pkg::KIND_TOTALS;
                unc_next   = {byte_total_reg, 3'b000};
                ocomp_next = comp_reg;
                pres_next  = 1'b0;
                freq_next  = '0;
                olen_next  = '0;
                oovf_next  = ovf_reg;
                st_next    = ST_RUN;
            end
            default: begin
                st_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_RUN;
            stage_v_reg    <= 1'b0;
            cnt_valid_reg  <= '0;
            len_valid_reg  <= '0;
            byte_total_reg <= '0;
            ovf_reg        <= 1'b0;
            fwd_v_reg      <= 1'b0;
            mv_reg         <= 1'b0;
            rd_v_reg       <= 1'b0;
        end else begin
            st_reg         <= st_next;
            stage_v_reg    <= stage_v_next;
            cnt_valid_reg  <= cnt_valid_next;
            len_valid_reg  <= len_valid_next;
            byte_total_reg <= byte_total_next;
            ovf_reg        <= ovf_next;
            fwd_v_reg      <= fwd_v_next;
            mv_reg         <= mv_next;
            rd_v_reg       <= rd_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_item_reg <= stage_item_next;
        fwd_addr_reg   <= fwd_addr_next;
        fwd_data_reg   <= fwd_data_next;
        kind_reg       <= kind_next;
        unc_reg        <= unc_next;
        ocomp_reg      <= ocomp_next;
        pres_reg       <= pres_next;
        freq_reg       <= freq_next;
        olen_reg       <= olen_next;
        oovf_reg       <= oovf_next;
        s_reg          <= s_next;
        used_reg       <= used_next;
        live_reg       <= live_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        best_ok_reg    <= best_ok_next;
        best_idx_reg   <= best_idx_next;
        best_w_reg     <= best_w_next;
        second_ok_reg  <= second_ok_next;
        second_idx_reg <= second_idx_next;
        second_w_reg   <= second_w_next;
        j_reg          <= j_next;
        prod_reg       <= prod_next;
        comp_reg       <= comp_next;
    end

    assign m_valid             = mv_reg;
    assign m_kind              = kind_reg;
    assign m_uncompressed_bits = unc_reg;
    assign m_compressed_bits   = ocomp_reg;
    assign m_present           = pres_reg;
    assign m_symbol_freq       = freq_reg;
    assign m_code_length       = olen_reg;
    assign m_overflow          = oovf_reg;

    a_pop_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> st_reg == ST_RUN)
        else $error("Item taken from the queue while the tree build is running.");

    a_merge_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_MERGE0 |-> best_ok_reg && second_ok_reg && best_idx_reg != second_idx_reg)
        else $error("Merge started without two distinct minimum nodes.");

    a_scan_live: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_SCAN |-> live_reg >= (SYM_W+1)'(2))
        else $error("Scan running with fewer than two live nodes.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(st_reg == ST_DONE) ||
                          $past(stage_v_reg && stage_item_reg.op == hclb_pkg::ACT_READ))
        else $error("Result raised without a readout or a finished build.");

endmodule

// File: design/huffman_code_length_builder_core.sv
// Bytes and clears: one transfer per cycle while no build runs; a last byte and a readout
// wait while a result is held; readouts go via the stage register to the result register.
// After a last byte the build loads the leaf weights, scans the node weight memory once per
// merge through its single read port, then finds the node depths and the code lengths.
// The totals result follows the build; input transfers are queued but not executed meanwhile.
// Reset clears counts, code lengths, the byte total, the overflow flag and all handshakes.
// ----------------------------------------------------------------------------
// Huffman code length builder core
// Top level joining the classifying input queue and the counting and build unit.
// ----------------------------------------------------------------------------
module huffman_code_length_builder_core #(
    parameter int SYMBOLS    = 128,
    parameter int COUNT_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [7:0]                  s_byte_value,
    input  logic                        s_last,
    input  logic [6:0]                  s_symbol,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [hclb_pkg::UNC_W-1:0]  m_uncompressed_bits,
    output logic [hclb_pkg::COMP_W-1:0] m_compressed_bits,
    output logic                        m_present,
    output logic [hclb_pkg::FREQ_W-1:0] m_symbol_freq,
    output logic [hclb_pkg::LEN_W-1:0]  m_code_length,
    output logic                        m_overflow
);

    logic            q_valid;
    logic            q_pop;
    hclb_pkg::item_t q_item;

    hclb_front #(.SYMBOLS(SYMBOLS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_byte_value (s_byte_value),
        .s_last       (s_last),
        .s_symbol     (s_symbol),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    hclb_back #(.SYMBOLS(SYMBOLS), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (q_valid),
        .q_item              (q_item),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_uncompressed_bits (m_uncompressed_bits),
        .m_compressed_bits   (m_compressed_bits),
        .m_present           (m_present),
        .m_symbol_freq       (m_symbol_freq),
        .m_code_length       (m_code_length),
        .m_overflow          (m_overflow)
    );

endmodule
